// ===== design/ile_pkg.sv =====
// ----------------------------------------------------------------------------
// ile_pkg
// Shared types and codes of the indexed list engine: request kinds, status
// codes and the decoded command that travels from front end to back end.
// ----------------------------------------------------------------------------
package ile_pkg;

	localparam int KIND_W  = 3;
	localparam int POS_W   = 7;
	localparam int VALUE_W = 64;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 7;

	localparam logic [KIND_W-1:0] KIND_INS_FRONT = 3'd0;
	localparam logic [KIND_W-1:0] KIND_INS_BACK  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_INS_AT    = 3'd2;
	localparam logic [KIND_W-1:0] KIND_READ_AT   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_REM_FRONT = 3'd4;
	localparam logic [KIND_W-1:0] KIND_REM_BACK  = 3'd5;
	localparam logic [KIND_W-1:0] KIND_REM_AT    = 3'd6;

	localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
	localparam logic [STAT_W-1:0] STAT_BAD  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

	typedef enum logic [1:0] {
		OP_INS,
		OP_READ,
		OP_REM,
		OP_BAD
	} op_t;

	typedef enum logic [1:0] {
		MODE_GIVEN,
		MODE_FRONT,
		MODE_BACK
	} mode_t;

	typedef struct packed {
		op_t                        op;
		mode_t                      mode;
		logic [POS_W-1:0]           pos;
		logic signed [VALUE_W-1:0]  value;
	} cmd_t;

endpackage

// ===== design/ile_ram.sv =====
// ----------------------------------------------------------------------------
// ile_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module ile_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/ile_queue.sv =====
// ----------------------------------------------------------------------------
// ile_queue
// Two-entry command queue between front end and back end.
// ----------------------------------------------------------------------------
module ile_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ile_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output ile_pkg::cmd_t head_cmd
);
	import ile_pkg::*;

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       do_push;
	logic       do_pop;

	assign full       = (fill_q == 2'd2);
	assign head_valid = (fill_q != 2'd0);
	assign head_cmd   = slot_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

// ===== design/ile_front.sv =====
// ----------------------------------------------------------------------------
// ile_front
// Request intake: registers each request, decodes its kind into an operation
// and a position mode, and hands it to the command queue.
// ----------------------------------------------------------------------------
module ile_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  logic [ile_pkg::KIND_W-1:0]        kind,
	input  logic [ile_pkg::POS_W-1:0]         position,
	input  logic signed [ile_pkg::VALUE_W-1:0] item_value,
	output logic                              push,
	output ile_pkg::cmd_t                     push_cmd,
	input  logic                              queue_full
);
	import ile_pkg::*;

	logic valid_s1;
	cmd_t cmd_s1;
	cmd_t dec_cmd;

	always_comb begin
		dec_cmd.pos   = position;
		dec_cmd.value = item_value;
		dec_cmd.mode  = MODE_GIVEN;
		dec_cmd.op    = OP_BAD;
		unique case (kind)
			KIND_INS_FRONT: begin
				dec_cmd.op   = OP_INS;
				dec_cmd.mode = MODE_FRONT;
			end
			KIND_INS_BACK: begin
				dec_cmd.op   = OP_INS;
				dec_cmd.mode = MODE_BACK;
			end
			KIND_INS_AT:    dec_cmd.op = OP_INS;
			KIND_READ_AT:   dec_cmd.op = OP_READ;
			KIND_REM_FRONT: begin
				dec_cmd.op   = OP_REM;
				dec_cmd.mode = MODE_FRONT;
			end
			KIND_REM_BACK: begin
				dec_cmd.op   = OP_REM;
				dec_cmd.mode = MODE_BACK;
			end
			KIND_REM_AT:    dec_cmd.op = OP_REM;
			default:        dec_cmd.op = OP_BAD;
		endcase
	end

	assign req_stall = valid_s1 && queue_full;
	assign push      = valid_s1 && !queue_full;
	assign push_cmd  = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			cmd_s1 <= dec_cmd;
		end
	end

endmodule

// ===== design/ile_back.sv =====
// ----------------------------------------------------------------------------
// ile_back
// List execution: checks each command against the current count, walks the
// link store one entry per cycle, updates links and pointers, and registers
// the response.
// ----------------------------------------------------------------------------
module ile_back #(
	parameter int CAPACITY = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cmd_valid,
	input  ile_pkg::cmd_t                      cmd,
	output logic                               cmd_pop,
	output logic                               rsp_valid,
	input  logic                               rsp_stall,
	output logic [ile_pkg::STAT_W-1:0]         status,
	output logic signed [ile_pkg::VALUE_W-1:0] result_value,
	output logic [ile_pkg::COUNT_W-1:0]        entry_count
);
	import ile_pkg::*;

	localparam int SW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > POS_W) ? CW : POS_W;
	localparam logic [CW-1:0] CAP_CNT  = CW'(CAPACITY);
	localparam logic [SW-1:0] LAST_IDX = SW'(CAPACITY - 1);

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_INS_FREE,
		ST_WALK,
		ST_INS_LINK1,
		ST_INS_LINK2,
		ST_RD_ISSUE,
		ST_RD_WAIT,
		ST_REM_FRONT,
		ST_REM_LINK,
		ST_REM_NEXT,
		ST_REM_GIVE
	} state_t;

	state_t                     state_q;
	logic [SW-1:0]              init_q;
	logic [SW-1:0]              first_q;
	logic [SW-1:0]              last_q;
	logic [SW-1:0]              free_q;
	logic [CW-1:0]              count_q;
	logic [SW-1:0]              slot_q;
	logic [SW-1:0]              cur_q;
	logic [SW-1:0]              prev_q;
	logic [PW-1:0]              rem_q;
	logic [PW-1:0]              epos_q;
	op_t                        op_q;
	logic signed [VALUE_W-1:0]  val_q;
	logic                       out_valid_q;
	logic [STAT_W-1:0]          status_q;
	logic signed [VALUE_W-1:0]  result_q;
	logic [COUNT_W-1:0]         count_out_q;

	logic [PW-1:0]              cnt_x;
	logic [PW-1:0]              epos;
	logic                       bad;
	logic                       full;
	logic                       go;

	logic                       lk_we;
	logic [SW-1:0]              lk_waddr;
	logic [SW-1:0]              lk_wdata;
	logic [SW-1:0]              lk_raddr;
	logic [SW-1:0]              lk_rdata;
	logic                       vl_we;
	logic [SW-1:0]              vl_raddr;
	logic [VALUE_W-1:0]         vl_rdata;

	ile_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_links (
		.clk   (clk),
		.we    (lk_we),
		.waddr (lk_waddr),
		.wdata (lk_wdata),
		.raddr (lk_raddr),
		.rdata (lk_rdata)
	);

	ile_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_values (
		.clk   (clk),
		.we    (vl_we),
		.waddr (free_q),
		.wdata (cmd.value),
		.raddr (vl_raddr),
		.rdata (vl_rdata)
	);

	assign cnt_x   = PW'(count_q);
	assign go      = (state_q == ST_IDLE) && cmd_valid && !out_valid_q;
	assign cmd_pop = go;

	// resolve the effective position and range-check against the count
	always_comb begin
		epos = PW'(cmd.pos);
		bad  = 1'b1;
		full = 1'b0;
		unique case (cmd.mode)
			MODE_FRONT: epos = '0;
			MODE_BACK:  epos = (cmd.op == OP_INS) ? cnt_x : cnt_x - PW'(1);
			default:    epos = PW'(cmd.pos);
		endcase
		unique case (cmd.op)
			OP_INS: begin
				bad  = epos > cnt_x;
				full = count_q == CAP_CNT;
			end
			OP_READ: bad = epos >= cnt_x;
			OP_REM:  bad = (count_q == '0) || (epos >= cnt_x);
			default: bad = 1'b1;
		endcase
	end

	always_comb begin
		lk_we    = 1'b0;
		lk_waddr = slot_q;
		lk_wdata = free_q;
		lk_raddr = first_q;
		vl_we    = 1'b0;
		vl_raddr = cur_q;
		unique case (state_q)
			ST_INIT: begin
				lk_we    = 1'b1;
				lk_waddr = init_q;
				lk_wdata = (init_q == LAST_IDX) ? '0 : init_q + SW'(1);
			end
			ST_IDLE: begin
				vl_raddr = first_q;
				if (go && cmd.op == OP_INS) begin
					lk_raddr = free_q;
					vl_we    = !bad && !full;
				end
			end
			ST_INS_FREE: begin
				if (count_q != '0 && epos_q == '0) begin
					lk_we    = 1'b1;
					lk_waddr = slot_q;
					lk_wdata = first_q;
				end else if (count_q != '0 && epos_q == cnt_x) begin
					lk_we    = 1'b1;
					lk_waddr = last_q;
					lk_wdata = slot_q;
				end
			end
			ST_WALK:  lk_raddr = lk_rdata;
			ST_INS_LINK1: begin
				lk_we    = 1'b1;
				lk_waddr = slot_q;
				lk_wdata = cur_q;
			end
			ST_INS_LINK2: begin
				lk_we    = 1'b1;
				lk_waddr = prev_q;
				lk_wdata = slot_q;
			end
			ST_REM_FRONT: begin
				lk_we    = 1'b1;
				lk_waddr = slot_q;
				lk_wdata = free_q;
			end
			ST_REM_LINK: lk_raddr = cur_q;
			ST_REM_NEXT: begin
				lk_we    = 1'b1;
				lk_waddr = prev_q;
				lk_wdata = lk_rdata;
			end
			ST_REM_GIVE: begin
				lk_we    = 1'b1;
				lk_waddr = cur_q;
				lk_wdata = free_q;
			end
			default: lk_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			init_q      <= '0;
			first_q     <= '0;
			last_q      <= '0;
			free_q      <= '0;
			count_q     <= '0;
			slot_q      <= '0;
			cur_q       <= '0;
			prev_q      <= '0;
			rem_q       <= '0;
			epos_q      <= '0;
			op_q        <= OP_BAD;
			val_q       <= '0;
			out_valid_q <= 1'b0;
			status_q    <= STAT_OK;
			result_q    <= '0;
			count_out_q <= '0;
		end else begin
			if (out_valid_q && !rsp_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_INIT: begin
					init_q <= init_q + SW'(1);
					if (init_q == LAST_IDX) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (go) begin
						op_q   <= cmd.op;
						epos_q <= epos;
						if (bad || full) begin
							out_valid_q <= 1'b1;
							status_q    <= bad ? STAT_BAD : STAT_FULL;
							result_q    <= '0;
							count_out_q <= COUNT_W'(count_q);
						end else begin
							unique case (cmd.op)
								OP_INS: begin
									slot_q  <= free_q;
									state_q <= ST_INS_FREE;
								end
								OP_READ: begin
									cur_q   <= first_q;
									rem_q   <= epos;
									state_q <= (epos == '0) ? ST_RD_ISSUE : ST_WALK;
								end
								default: begin
									if (epos == '0) begin
										slot_q  <= first_q;
										state_q <= ST_REM_FRONT;
									end else begin
										cur_q   <= first_q;
										rem_q   <= epos;
										state_q <= ST_WALK;
									end
								end
							endcase
						end
					end
				end
				ST_INS_FREE: begin
					free_q <= lk_rdata;
					if (count_q == '0 || epos_q == '0 || epos_q == cnt_x) begin
						if (count_q == '0 || epos_q == '0) begin
							first_q <= slot_q;
						end
						if (count_q == '0 || epos_q == cnt_x) begin
							last_q <= slot_q;
						end
						count_q     <= count_q + CW'(1);
						out_valid_q <= 1'b1;
						status_q    <= STAT_OK;
						result_q    <= '0;
						count_out_q <= COUNT_W'(count_q + CW'(1));
						state_q     <= ST_IDLE;
					end else begin
						cur_q   <= first_q;
						rem_q   <= epos_q;
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					// advance one link per cycle; read data is link of cur_q
					prev_q <= cur_q;
					cur_q  <= lk_rdata;
					rem_q  <= rem_q - PW'(1);
					if (rem_q == PW'(1)) begin
						unique case (op_q)
							OP_INS:  state_q <= ST_INS_LINK1;
							OP_READ: state_q <= ST_RD_ISSUE;
							default: state_q <= ST_REM_LINK;
						endcase
					end
				end
				ST_INS_LINK1: state_q <= ST_INS_LINK2;
				ST_INS_LINK2: begin
					count_q     <= count_q + CW'(1);
					out_valid_q <= 1'b1;
					status_q    <= STAT_OK;
					result_q    <= '0;
					count_out_q <= COUNT_W'(count_q + CW'(1));
					state_q     <= ST_IDLE;
				end
				ST_RD_ISSUE: state_q <= ST_RD_WAIT;
				ST_RD_WAIT: begin
					out_valid_q <= 1'b1;
					status_q    <= STAT_OK;
					result_q    <= vl_rdata;
					count_out_q <= COUNT_W'(count_q);
					state_q     <= ST_IDLE;
				end
				ST_REM_FRONT: begin
					if (count_q == CW'(1)) begin
						first_q <= '0;
						last_q  <= '0;
					end else begin
						first_q <= lk_rdata;
					end
					free_q      <= slot_q;
					count_q     <= count_q - CW'(1);
					out_valid_q <= 1'b1;
					status_q    <= STAT_OK;
					result_q    <= vl_rdata;
					count_out_q <= COUNT_W'(count_q - CW'(1));
					state_q     <= ST_IDLE;
				end
				ST_REM_LINK: state_q <= ST_REM_NEXT;
				ST_REM_NEXT: begin
					val_q <= vl_rdata;
					if (epos_q == cnt_x - PW'(1)) begin
						last_q <= prev_q;
					end
					state_q <= ST_REM_GIVE;
				end
				ST_REM_GIVE: begin
					free_q      <= cur_q;
					count_q     <= count_q - CW'(1);
					out_valid_q <= 1'b1;
					status_q    <= STAT_OK;
					result_q    <= val_q;
					count_out_q <= COUNT_W'(count_q - CW'(1));
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp_valid    = out_valid_q;
	assign status       = status_q;
	assign result_value = result_q;
	assign entry_count  = count_out_q;

endmodule

// ===== design/indexed_list_engine.sv =====
// ----------------------------------------------------------------------------
// indexed_list_engine
// Bounded ordered list of signed 64-bit values held as linked entries.
// ----------------------------------------------------------------------------
// Requests enter on the req channel (req_valid/req_stall with kind, position,
// item_value); one response per request leaves on the rsp channel
// (rsp_valid/rsp_stall with status, result_value, entry_count), in order.
// A front end registers and decodes each request into a two-entry command
// queue; the back end executes one command at a time against the link and
// value RAMs and holds its response in an output register.
// Insert at the front or back and remove at the front need no walk; read,
// insert or remove at position p walk p links, reading one link per cycle
// from the single link RAM read port. Remove at the back walks to the last
// entry, so it is positional. The next command starts only after the
// response is taken.
// After reset the back end first builds the free-slot chain in the link
// RAM; requests queue up meanwhile and then stall.
// While the receiver stalls, the response holds; the back end takes no new
// command, and the front end keeps accepting until the queue fills.
// ----------------------------------------------------------------------------
module indexed_list_engine #(
	parameter int CAPACITY = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	output logic                               req_stall,
	input  logic [ile_pkg::KIND_W-1:0]         kind,
	input  logic [ile_pkg::POS_W-1:0]          position,
	input  logic signed [ile_pkg::VALUE_W-1:0] item_value,
	output logic                               rsp_valid,
	input  logic                               rsp_stall,
	output logic [ile_pkg::STAT_W-1:0]         status,
	output logic signed [ile_pkg::VALUE_W-1:0] result_value,
	output logic [ile_pkg::COUNT_W-1:0]        entry_count
);
	import ile_pkg::*;

	logic push;
	cmd_t push_cmd;
	logic queue_full;
	logic head_valid;
	cmd_t head_cmd;
	logic cmd_pop;

	ile_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.kind       (kind),
		.position   (position),
		.item_value (item_value),
		.push       (push),
		.push_cmd   (push_cmd),
		.queue_full (queue_full)
	);

	ile_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (queue_full),
		.pop        (cmd_pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	ile_back #(.CAPACITY(CAPACITY)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (head_valid),
		.cmd          (head_cmd),
		.cmd_pop      (cmd_pop),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.status       (status),
		.result_value (result_value),
		.entry_count  (entry_count)
	);

endmodule
